// File: rtl/core/atrc_pkg.sv
package atrc_pkg;

   localparam int DEF_CHANNELS    = 9;
   localparam int DEF_SAMPLE_BITS = 12;

   localparam int CHAN_W     = 4;
   localparam int RUN_W      = 4;
   localparam int SCAN_W     = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int RST_LOW_THRESHOLD  = 410;
   localparam int RST_HIGH_THRESHOLD = 3685;
   localparam logic [RUN_W-1:0]  RST_QUALIFY_COUNT = 4'd3;
   localparam logic [SCAN_W-1:0] RST_TIMEOUT_SCANS = 16'd9000;

   typedef enum logic {
      OP_RESTART = 1'b0,
      OP_SAMPLE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      VERDICT_RUN  = 2'd0,
      VERDICT_PASS = 2'd1,
      VERDICT_FAIL = 2'd2
   } verdict_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_THRESHOLD  = 2'd0,
      CSR_HIGH_THRESHOLD = 2'd1,
      CSR_QUALIFY_COUNT  = 2'd2,
      CSR_TIMEOUT_SCANS  = 2'd3
   } csr_idx_type;

endpackage

// File: rtl/core/analog_travel_range_checker.sv
// Analog travel range checker.
// req_ carries one transaction per converter reading: tuser is the operation
// (restart or sample), tlast marks the last channel of a scan, tdata holds the
// channel and the sample. rsp_ returns exactly one transaction per request with
// the channel's running min/max, its low/high seen flags and the verdict.
// csr_ writes the thresholds, qualify count and timeout; the user must write
// them only while the block is idle, which the block itself does not enforce.
// Per-channel state (min, max, run counters, flags) lives in one RAM with a
// registered read; a valid bit per channel makes restart and reset instant,
// so there is no clearing pass. The RAM read is issued when a request is
// taken; the entry is updated and written back when the update stage
// advances, and a one-entry forward register covers back-to-back hits on
// the same channel.
// Throughput: one transaction per cycle while rsp_tready is high, set by the
// single read-modify-write of the state RAM.
// Reset clears the verdict, scan counter, valid bits and pending transactions
// and restores the register defaults. When rsp_tready is low the response is
// held, one more request is still taken into the update stage, then req_tready
// drops until the response moves.
module analog_travel_range_checker import atrc_pkg::*; #(
   parameter int CHANNELS    = DEF_CHANNELS,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   localparam int REQ_W = ((CHAN_W + SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((CHAN_W + 2 * SAMPLE_BITS + 4 + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // channel, sample, zero pad
   input  logic                  req_tuser,   // operation
   input  logic                  req_tlast,   // scan_end
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // out_channel, lowest, highest,
                                              // low_seen, high_seen, verdict, pad
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int RSP_F_W = CHAN_W + 2 * SAMPLE_BITS + 4;
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] lo;
      logic [SAMPLE_BITS-1:0] hi;
      logic [RUN_W-1:0]       low_run;
      logic [RUN_W-1:0]       high_run;
      logic                   low_seen;
      logic                   high_seen;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
   localparam entry_type RESET_ENTRY = '{lo: FULL_SCALE, hi: '0, low_run: '0,
                                         high_run: '0, low_seen: 1'b0, high_seen: 1'b0};

   // configuration
   logic [SAMPLE_BITS-1:0] low_thr_ff, low_thr_in;
   logic [SAMPLE_BITS-1:0] high_thr_ff, high_thr_in;
   logic [RUN_W-1:0]       qual_ff, qual_in;
   logic [SCAN_W-1:0]      timeout_ff, timeout_in;

   // update stage
   logic                   s1_valid_ff, s1_valid_in;
   op_type                 s1_op_ff, s1_op_in;
   logic [CHAN_W-1:0]      s1_chan_ff, s1_chan_in;
   logic [SAMPLE_BITS-1:0] s1_sample_ff, s1_sample_in;
   logic                   s1_last_ff, s1_last_in;

   // block state outside the RAM
   logic [CHANNELS-1:0]    entry_valid_ff, entry_valid_in;
   logic [CHANNELS-1:0]    covered_ff, covered_in;
   logic [SCAN_W-1:0]      scan_cnt_ff, scan_cnt_in;
   verdict_type            verdict_ff, verdict_in;
   logic                   fwd_valid_ff, fwd_valid_in;
   logic [CHAN_W-1:0]      fwd_chan_ff, fwd_chan_in;
   entry_type              fwd_entry_ff, fwd_entry_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   advance;
   logic [CHAN_W-1:0]      req_channel;
   logic [SAMPLE_BITS-1:0] req_sample;
   logic [ENTRY_W-1:0]     ram_rd_data;
   logic [AW-1:0]          s1_addr;
   logic                   s1_chan_ok;
   logic                   do_update;
   logic [RUN_W-1:0]       need;
   logic                   low_hit, high_hit;
   entry_type              cur_entry, nxt_entry, view_entry;
   logic [CHANNELS-1:0]    chan_sel;
   logic [CHANNELS-1:0]    covered_upd;
   logic [SCAN_W-1:0]      scan_cnt_inc;
   logic [RSP_F_W-1:0]     rsp_fields;

   assign req_channel = req_tdata[CHAN_W-1:0];
   assign req_sample  = req_tdata[CHAN_W +: SAMPLE_BITS];

   assign advance    = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | advance;
   assign accept     = req_tvalid & req_tready;

   assign s1_addr    = s1_chan_ff[AW-1:0];
   assign s1_chan_ok = {1'b0, s1_chan_ff} < (CHAN_W + 1)'(CHANNELS);

   atrc_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(CHANNELS)
   ) u_state_ram (
      .clock  (clock),
      .wr_en  (advance & do_update),
      .wr_addr(s1_addr),
      .wr_data(nxt_entry),
      .rd_en  (accept),
      .rd_addr(req_channel[AW-1:0]),
      .rd_data(ram_rd_data)
   );

   // configuration writes
   always_comb begin
      low_thr_in  = low_thr_ff;
      high_thr_in = high_thr_ff;
      qual_in     = qual_ff;
      timeout_in  = timeout_ff;
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LOW_THRESHOLD:  low_thr_in  = csr_wdata[SAMPLE_BITS-1:0];
            CSR_HIGH_THRESHOLD: high_thr_in = csr_wdata[SAMPLE_BITS-1:0];
            CSR_QUALIFY_COUNT:  qual_in     = csr_wdata[RUN_W-1:0];
            CSR_TIMEOUT_SCANS:  timeout_in  = csr_wdata[SCAN_W-1:0];
         endcase
      end
   end

   // stage 1 capture
   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_op_in     = accept ? op_type'(req_tuser) : s1_op_ff;
      s1_chan_in   = accept ? req_channel : s1_chan_ff;
      s1_sample_in = accept ? req_sample : s1_sample_ff;
      s1_last_in   = accept ? req_tlast : s1_last_ff;
   end

   // entry update; the forward register holds the last write-back
   always_comb begin
      if (fwd_valid_ff && fwd_chan_ff == s1_chan_ff) begin
         cur_entry = fwd_entry_ff;
      end else if (s1_chan_ok && entry_valid_ff[s1_addr]) begin
         cur_entry = entry_type'(ram_rd_data);
      end else begin
         cur_entry = RESET_ENTRY;
      end

      need     = (qual_ff == '0) ? RUN_W'(1) : qual_ff;
      low_hit  = s1_sample_ff <= low_thr_ff;
      high_hit = s1_sample_ff >= high_thr_ff;

      nxt_entry    = cur_entry;
      nxt_entry.lo = (s1_sample_ff < cur_entry.lo) ? s1_sample_ff : cur_entry.lo;
      nxt_entry.hi = (s1_sample_ff > cur_entry.hi) ? s1_sample_ff : cur_entry.hi;
      if (!low_hit) begin
         nxt_entry.low_run = '0;
      end else if (cur_entry.low_run < need) begin
         nxt_entry.low_run = cur_entry.low_run + RUN_W'(1);
      end
      if (!high_hit) begin
         nxt_entry.high_run = '0;
      end else if (cur_entry.high_run < need) begin
         nxt_entry.high_run = cur_entry.high_run + RUN_W'(1);
      end
      nxt_entry.low_seen  = cur_entry.low_seen | (nxt_entry.low_run >= need);
      nxt_entry.high_seen = cur_entry.high_seen | (nxt_entry.high_run >= need);

      do_update = (s1_op_ff == OP_SAMPLE) && (verdict_ff == VERDICT_RUN) && s1_chan_ok;

      if (s1_op_ff == OP_RESTART) begin
         view_entry = RESET_ENTRY;
      end else if (do_update) begin
         view_entry = nxt_entry;
      end else begin
         view_entry = cur_entry;
      end
   end

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         chan_sel[i] = s1_chan_ok && (s1_addr == AW'(i));
      end
      covered_upd = covered_ff;
      if (do_update && nxt_entry.low_seen && nxt_entry.high_seen) begin
         covered_upd = covered_ff | chan_sel;
      end
      scan_cnt_inc = (scan_cnt_ff == '1) ? scan_cnt_ff : scan_cnt_ff + SCAN_W'(1);
   end

   // block state
   always_comb begin
      entry_valid_in = entry_valid_ff;
      covered_in     = covered_ff;
      scan_cnt_in    = scan_cnt_ff;
      verdict_in     = verdict_ff;
      fwd_valid_in   = fwd_valid_ff;
      fwd_chan_in    = fwd_chan_ff;
      fwd_entry_in   = fwd_entry_ff;
      if (advance) begin
         if (s1_op_ff == OP_RESTART) begin
            entry_valid_in = '0;
            covered_in     = '0;
            scan_cnt_in    = '0;
            verdict_in     = VERDICT_RUN;
            fwd_valid_in   = 1'b0;
         end else if (verdict_ff == VERDICT_RUN) begin
            covered_in = covered_upd;
            if (do_update) begin
               entry_valid_in = entry_valid_ff | chan_sel;
               fwd_valid_in   = 1'b1;
               fwd_chan_in    = s1_chan_ff;
               fwd_entry_in   = nxt_entry;
            end
            if (s1_last_ff) begin
               if (&covered_upd) begin
                  verdict_in = VERDICT_PASS;
               end else begin
                  scan_cnt_in = scan_cnt_inc;
                  if (scan_cnt_inc >= timeout_ff) begin
                     verdict_in = VERDICT_FAIL;
                  end
               end
            end
         end
      end
   end

   // response
   always_comb begin
      rsp_fields = {verdict_in,
                    s1_chan_ok & view_entry.high_seen,
                    s1_chan_ok & view_entry.low_seen,
                    s1_chan_ok ? view_entry.hi : SAMPLE_BITS'(0),
                    s1_chan_ok ? view_entry.lo : SAMPLE_BITS'(0),
                    s1_chan_ff};
      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rsp_data_in  = advance ? RSP_W'(rsp_fields) : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_thr_ff     <= SAMPLE_BITS'(RST_LOW_THRESHOLD);
         high_thr_ff    <= SAMPLE_BITS'(RST_HIGH_THRESHOLD);
         qual_ff        <= RST_QUALIFY_COUNT;
         timeout_ff     <= RST_TIMEOUT_SCANS;
         s1_valid_ff    <= 1'b0;
         entry_valid_ff <= '0;
         covered_ff     <= '0;
         scan_cnt_ff    <= '0;
         verdict_ff     <= VERDICT_RUN;
         fwd_valid_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         low_thr_ff     <= low_thr_in;
         high_thr_ff    <= high_thr_in;
         qual_ff        <= qual_in;
         timeout_ff     <= timeout_in;
         s1_valid_ff    <= s1_valid_in;
         entry_valid_ff <= entry_valid_in;
         covered_ff     <= covered_in;
         scan_cnt_ff    <= scan_cnt_in;
         verdict_ff     <= verdict_in;
         fwd_valid_ff   <= fwd_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff     <= s1_op_in;
      s1_chan_ff   <= s1_chan_in;
      s1_sample_ff <= s1_sample_in;
      s1_last_ff   <= s1_last_in;
      fwd_chan_ff  <= fwd_chan_in;
      fwd_entry_ff <= fwd_entry_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/core/atrc_ram.sv
module atrc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: bench/analog_travel_range_checker_tb.sv
`timescale 1ns / 1ps

module analog_travel_range_checker_tb;
   import atrc_pkg::*;

   localparam int CHANNELS = DEF_CHANNELS;
   localparam int PHASE_ITEMS = 235;
   localparam int HOLD_OFF_CYCLES = 300;

   typedef struct {
      op_type      op;
      logic [3:0]  chan;
      logic [11:0] smp;
      logic        last;
   } sample_req_type;

   typedef struct {
      logic [3:0]  chan;
      logic [11:0] lowest;
      logic [11:0] highest;
      logic        low_seen;
      logic        high_seen;
      verdict_type verdict;
   } travel_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [15:0]           req_tdata = '0;    // channel, sample
   logic                  req_tuser = 1'b0;  // operation
   logic                  req_tlast = 1'b0;  // scan_end
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;         // out_channel, lowest, highest,
                                             // low_seen, high_seen, verdict
   logic                  csr_wr_en = 1'b0;
   csr_idx_type           csr_index = CSR_LOW_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // travel tracking state
   logic [11:0] chan_min [CHANNELS];
   logic [11:0] chan_max [CHANNELS];
   logic [3:0]  low_run [CHANNELS];
   logic [3:0]  high_run [CHANNELS];
   logic        seen_lo [CHANNELS];
   logic        seen_hi [CHANNELS];
   logic [15:0] scans_done;
   verdict_type verdict_now;

   logic [11:0] low_thr;
   logic [11:0] high_thr;
   logic [3:0]  qualify_cfg;
   logic [15:0] timeout_cfg;

   sample_req_type queued_samples[$];
   travel_rsp_type travel_reports[$];
   int samples_queued = 0;
   int samples_taken = 0;
   int phase_queued;
   int error_count = 0;

   int send_idle = 29;
   int recv_idle = 63;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   logic req_done = 1'b0;

   always #5 clock = ~clock;

   analog_travel_range_checker DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   task automatic clear_travel();
      for (int c = 0; c < CHANNELS; c++) begin
         chan_min[c] = 12'hFFF;
         chan_max[c] = '0;
         low_run[c] = '0;
         high_run[c] = '0;
         seen_lo[c] = 1'b0;
         seen_hi[c] = 1'b0;
      end
      scans_done = '0;
      verdict_now = VERDICT_RUN;
   endtask

   task automatic track_travel(input sample_req_type it, output travel_rsp_type r);
      logic [3:0] need;
      logic       covered;
      need = (qualify_cfg == 4'd0) ? 4'd1 : qualify_cfg;
      if (it.op == OP_RESTART) begin
         clear_travel();
      end else if (verdict_now == VERDICT_RUN) begin
         if (it.chan < CHANNELS) begin
            if (it.smp < chan_min[it.chan]) chan_min[it.chan] = it.smp;
            if (it.smp > chan_max[it.chan]) chan_max[it.chan] = it.smp;
            if (it.smp <= low_thr) begin
               if (low_run[it.chan] < need) low_run[it.chan] = low_run[it.chan] + 4'd1;
            end else begin
               low_run[it.chan] = '0;
            end
            if (it.smp >= high_thr) begin
               if (high_run[it.chan] < need) high_run[it.chan] = high_run[it.chan] + 4'd1;
            end else begin
               high_run[it.chan] = '0;
            end
            if (low_run[it.chan] >= need) seen_lo[it.chan] = 1'b1;
            if (high_run[it.chan] >= need) seen_hi[it.chan] = 1'b1;
         end
         if (it.last) begin
            covered = 1'b1;
            for (int c = 0; c < CHANNELS; c++)
               if (!(seen_lo[c] && seen_hi[c])) covered = 1'b0;
            if (covered) begin
               verdict_now = VERDICT_PASS;
            end else begin
               if (scans_done != 16'hFFFF) scans_done = scans_done + 16'd1;
               if (scans_done >= timeout_cfg) verdict_now = VERDICT_FAIL;
            end
         end
      end
      r.chan = it.chan;
      r.verdict = verdict_now;
      if (it.chan < CHANNELS) begin
         r.lowest = chan_min[it.chan];
         r.highest = chan_max[it.chan];
         r.low_seen = seen_lo[it.chan];
         r.high_seen = seen_hi[it.chan];
      end else begin
         r.lowest = '0;
         r.highest = '0;
         r.low_seen = 1'b0;
         r.high_seen = 1'b0;
      end
   endtask

   // request driver
   always @(negedge clock) begin
      sample_req_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_done) begin
         if (queued_samples.size() != 0 && $urandom_range(99) >= send_idle) begin
            it = queued_samples.pop_front();
            req_tdata <= {it.smp, it.chan};
            req_tuser <= it.op;
            req_tlast <= it.last;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response back-pressure, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         rsp_tready <= 1'b0;
         hold_served <= hold_served + 1;
         hold_left <= HOLD_OFF_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // monitor: predict on each request transaction, check each response
   always @(posedge clock) begin
      sample_req_type got;
      travel_rsp_type want;
      if (reset) begin
         req_done <= 1'b0;
      end else begin
         req_done <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            got.op = op_type'(req_tuser);
            got.chan = req_tdata[3:0];
            got.smp = req_tdata[15:4];
            got.last = req_tlast;
            track_travel(got, want);
            travel_reports.push_back(want);
            samples_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (travel_reports.size() == 0) begin
               $error("response transaction with nothing expected: %h", rsp_tdata);
               error_count++;
            end else begin
               want = travel_reports.pop_front();
               if (rsp_tdata[3:0] !== want.chan) begin
                  $error("out_channel: expected %0d, actual %0d", want.chan, rsp_tdata[3:0]);
                  error_count++;
               end
               if (rsp_tdata[15:4] !== want.lowest) begin
                  $error("lowest: expected %0d, actual %0d", want.lowest, rsp_tdata[15:4]);
                  error_count++;
               end
               if (rsp_tdata[27:16] !== want.highest) begin
                  $error("highest: expected %0d, actual %0d", want.highest, rsp_tdata[27:16]);
                  error_count++;
               end
               if (rsp_tdata[28] !== want.low_seen) begin
                  $error("low_seen: expected %0d, actual %0d", want.low_seen, rsp_tdata[28]);
                  error_count++;
               end
               if (rsp_tdata[29] !== want.high_seen) begin
                  $error("high_seen: expected %0d, actual %0d", want.high_seen, rsp_tdata[29]);
                  error_count++;
               end
               if (rsp_tdata[31:30] !== want.verdict) begin
                  $error("verdict: expected %0d, actual %0d", want.verdict, rsp_tdata[31:30]);
                  error_count++;
               end
            end
         end
      end
   end

   task automatic queue_item(op_type op, logic [3:0] ch, logic [11:0] smp, logic last);
      sample_req_type it;
      it.op = op;
      it.chan = ch;
      it.smp = smp;
      it.last = last;
      queued_samples.push_back(it);
      samples_queued++;
      phase_queued++;
   endtask

   task automatic queue_noise();
      queue_item(($urandom_range(9) == 0) ? OP_RESTART : OP_SAMPLE, 4'($urandom_range(15)),
                 12'($urandom_range(4095)), 1'($urandom_range(1)));
   endtask

   // restart, then scans where each channel sits at one end of its travel and
   // then moves to the other end; noise items and dropped channels are mixed in
   task automatic queue_session();
      int need;
      int scans;
      int flip_at [CHANNELS];
      logic high_first [CHANNELS];
      int roll;
      logic at_high;
      logic [11:0] smp;
      need = (qualify_cfg == 4'd0) ? 1 : int'(qualify_cfg);
      scans = $urandom_range(2 * need + 6, 2 * need + 1);
      for (int c = 0; c < CHANNELS; c++) begin
         flip_at[c] = $urandom_range(scans - need, need);
         high_first[c] = 1'($urandom_range(1));
      end
      queue_item(OP_RESTART, 4'($urandom_range(15)), 12'($urandom_range(4095)),
                 1'($urandom_range(1)));
      for (int s = 0; s < scans; s++) begin
         for (int c = 0; c < CHANNELS; c++) begin
            roll = $urandom_range(99);
            if (roll < 3) queue_noise();
            // occasionally drop a channel to break the scan
            if (roll >= 3 && roll < 5 && c != CHANNELS - 1) continue;
            at_high = (s >= flip_at[c]) ^ high_first[c];
            if (roll >= 95) smp = 12'($urandom_range(4095));
            else if (at_high) smp = 12'($urandom_range(4095, high_thr));
            else smp = 12'($urandom_range(low_thr, 0));
            queue_item(OP_SAMPLE, 4'(c), smp, c == CHANNELS - 1);
         end
      end
   endtask

   task automatic wait_drained();
      while (samples_taken != samples_queued || travel_reports.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_settings(logic [11:0] lo, logic [11:0] hi, logic [3:0] q,
                                logic [15:0] to);
      low_thr = lo;
      high_thr = hi;
      qualify_cfg = q;
      timeout_cfg = to;
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_LOW_THRESHOLD;
      csr_wdata <= CSR_DATA_W'(lo);
      @(negedge clock);
      csr_index <= CSR_HIGH_THRESHOLD;
      csr_wdata <= CSR_DATA_W'(hi);
      @(negedge clock);
      csr_index <= CSR_QUALIFY_COUNT;
      csr_wdata <= CSR_DATA_W'(q);
      @(negedge clock);
      csr_index <= CSR_TIMEOUT_SCANS;
      csr_wdata <= to;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(logic [11:0] lo, logic [11:0] hi, logic [3:0] q,
                            logic [15:0] to, int snd, int rcv, logic long_hold);
      load_settings(lo, hi, q, to);
      @(posedge clock);
      send_idle = snd;
      recv_idle = rcv;
      if (long_hold) hold_asked++;
      phase_queued = 0;
      while (phase_queued < PHASE_ITEMS) queue_session();
      wait_drained();
   endtask

   initial begin
      low_thr = 12'(RST_LOW_THRESHOLD);
      high_thr = 12'(RST_HIGH_THRESHOLD);
      qualify_cfg = RST_QUALIFY_COUNT;
      timeout_cfg = RST_TIMEOUT_SCANS;
      clear_travel();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part on reset settings
      queue_item(OP_RESTART, 4'd0, 12'd0, 1'b0);
      queue_item(OP_RESTART, 4'd15, 12'hFFF, 1'b1);   // restart on a bad channel
      queue_item(OP_SAMPLE, 4'd0, 12'd0, 1'b0);
      queue_item(OP_SAMPLE, 4'd0, 12'hFFF, 1'b0);
      // low end: exactly at threshold, then below, qualifies on the third; high end likewise
      queue_item(OP_SAMPLE, 4'd1, 12'd410, 1'b0);
      queue_item(OP_SAMPLE, 4'd1, 12'd0, 1'b0);
      queue_item(OP_SAMPLE, 4'd1, 12'd409, 1'b0);
      queue_item(OP_SAMPLE, 4'd1, 12'd411, 1'b0);
      queue_item(OP_SAMPLE, 4'd1, 12'd3685, 1'b0);
      queue_item(OP_SAMPLE, 4'd1, 12'hFFF, 1'b0);
      queue_item(OP_SAMPLE, 4'd1, 12'd3686, 1'b0);
      queue_item(OP_SAMPLE, 4'd1, 12'd3684, 1'b0);
      // out-of-range channels still end a scan
      queue_item(OP_SAMPLE, 4'd9, 12'hAAA, 1'b1);
      queue_item(OP_SAMPLE, 4'd15, 12'h555, 1'b0);
      queue_item(OP_SAMPLE, 4'd8, 12'h555, 1'b1);
      queue_item(OP_SAMPLE, 4'd7, 12'hAAA, 1'b0);
      queue_item(OP_SAMPLE, 4'd2, 12'h800, 1'b1);
      queue_item(OP_RESTART, 4'd12, 12'h7FF, 1'b0);
      wait_drained();

      run_phase(12'($urandom_range(1500, 200)), 12'($urandom_range(3900, 2600)),
                4'($urandom_range(4, 1)), 16'($urandom_range(40, 6)), 29, 63, 1'b0);
      run_phase(12'd0, 12'hFFF, 4'd15, 16'hFFFF, 29, 63, 1'b1);
      run_phase(12'hFFF, 12'd0, 4'd0, 16'd0, 29, 63, 1'b0);
      run_phase(12'($urandom_range(1500, 200)), 12'($urandom_range(3900, 2600)),
                4'($urandom_range(4, 1)), 16'($urandom_range(40, 6)), 63, 29, 1'b0);
      run_phase(12'($urandom_range(4095)), 12'($urandom_range(4095)), 4'd1, 16'd1,
                63, 29, 1'b0);
      run_phase(12'($urandom_range(2000, 0)), 12'($urandom_range(4095, 2000)),
                4'($urandom_range(6, 2)), 16'($urandom_range(60, 4)), 63, 29, 1'b0);
      run_phase(12'(RST_LOW_THRESHOLD), 12'(RST_HIGH_THRESHOLD), RST_QUALIFY_COUNT,
                RST_TIMEOUT_SCANS, 0, 0, 1'b1);
      run_phase(12'($urandom_range(1500, 100)), 12'($urandom_range(4000, 2600)),
                4'($urandom_range(15)), 16'($urandom_range(50, 5)), 0, 0, 1'b0);

      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("analog_travel_range_checker_tb passed");
      end else begin
         $display("analog_travel_range_checker_tb failed");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("analog_travel_range_checker_tb failed");
      $finish;
   end

endmodule

// File: sim.f
rtl/core/atrc_pkg.sv
rtl/core/atrc_ram.sv
rtl/core/analog_travel_range_checker.sv
bench/analog_travel_range_checker_tb.sv
